[hdl/mcp_pkg.sv]
// Package for the Morse character player: phase codes, register indexes,
// shared structs and the character to pattern lookup.
// No dependencies; imported by every module of the block.
`default_nettype none
package mcp_pkg;

   localparam int PHASE_W = 3;
   localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_HIGH   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_LOW    = 3'd2;
   localparam logic [PHASE_W-1:0] PH_EGAP   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_CGAP   = 3'd4;
   localparam logic [PHASE_W-1:0] PH_FINISH = 3'd5;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLES      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_GAP    = 2'd2;

   localparam int CSR_DATA_W = 16;
   localparam int TICK_W     = 20;
   localparam int CYCLE_W    = 9;

   localparam logic [15:0] HALF_PERIOD_RST = 16'd500;
   localparam logic [7:0]  CYCLES_RST      = 8'd75;
   localparam logic [15:0] UNIT_GAP_RST    = 16'd15000;

   typedef struct packed {
      logic [15:0] half_period;
      logic [7:0]  cycles;
      logic [15:0] unit_gap;
   } cfg_type;

   typedef struct packed {
      logic       func;
      logic [7:0] char_code;
      logic       end_of_message;
   } item_type;

   // packed from the top down so that speaker_level lands in bit 0
   typedef struct packed {
      logic accepted;
      logic busy_res;
      logic green_lamp;
      logic yellow_lamp;
      logic red_lamp;
      logic speaker_level;
   } result_type;

   // bits 4:0 pattern (1 = dash, element 0 first), bits 7:5 length
   localparam logic [7:0] LETTER_TAB [26] = '{
      8'h42, 8'h81, 8'h85, 8'h61, 8'h20, 8'h84, 8'h63, 8'h80,
      8'h40, 8'h8E, 8'h65, 8'h82, 8'h43, 8'h41, 8'h67, 8'h86,
      8'h8B, 8'h62, 8'h60, 8'h21, 8'h64, 8'h88, 8'h66, 8'h89,
      8'h8D, 8'h83
   };

   localparam logic [4:0] DIGIT_TAB [10] = '{
      5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3, 5'd7, 5'd15
   };

   function automatic logic [7:0] char_lookup(input logic [7:0] ch);
      logic [7:0] offs;
      logic [7:0] entry;
      offs  = 8'd0;
      entry = 8'd0;
      if (ch >= 8'h41 && ch <= 8'h5A) begin
         offs  = ch - 8'h41;
         entry = LETTER_TAB[offs[4:0]];
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
         offs  = ch - 8'h61;
         entry = LETTER_TAB[offs[4:0]];
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         offs  = ch - 8'h30;
         entry = {3'd5, DIGIT_TAB[offs[3:0]]};
      end
      return entry;
   endfunction

   function automatic logic is_dash(input logic [4:0] bits, input logic [2:0] idx);
      logic [7:0] ext;
      ext = {3'd0, bits};
      return ext[idx];
   endfunction

endpackage
`default_nettype wire

[hdl/mcp_in_stage.sv]
// Input register of the Morse character player: holds one request
// transaction until the player takes it. Depends on mcp_pkg.
`default_nettype none
module mcp_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,
   input  wire logic              req_tlast,
   input  wire logic              req_tuser,
   input  wire logic              take,
   output logic                   item_valid,
   output mcp_pkg::item_type      item
);
   import mcp_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign req_tready = !valid_ff || take;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= '{func: req_tuser, char_code: req_tdata,
                      end_of_message: req_tlast};
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

[hdl/mcp_player.sv]
// Player state and its one-step update: phase, counters and pattern,
// with the lamp and speaker result of each step. Depends on mcp_pkg.
`default_nettype none
module mcp_player (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire mcp_pkg::item_type item,
   input  wire mcp_pkg::cfg_type  cfg,
   output mcp_pkg::result_type    result
);
   import mcp_pkg::*;

   logic [4:0]         bits_ff, bits_in;
   logic [2:0]         len_ff, len_in;
   logic [2:0]         idx_ff, idx_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [CYCLE_W-1:0] cyc_ff, cyc_in;
   logic               last_ff, last_in;
   logic               accepted;

   logic [15:0]        half1, gap1;
   logic [7:0]         cyc1;
   logic [7:0]         entry;
   logic [TICK_W-1:0]  tick_dec;
   logic [CYCLE_W-1:0] cyc_dec;
   logic [2:0]         idx_inc;
   logic               sounding, dash;

   assign half1    = (cfg.half_period == 16'd0) ? 16'd1 : cfg.half_period;
   assign gap1     = (cfg.unit_gap == 16'd0) ? 16'd1 : cfg.unit_gap;
   assign cyc1     = (cfg.cycles == 8'd0) ? 8'd1 : cfg.cycles;
   assign entry    = char_lookup(item.char_code);
   assign tick_dec = tick_ff - TICK_W'(1);
   assign cyc_dec  = cyc_ff - CYCLE_W'(1);
   assign idx_inc  = idx_ff + 3'd1;

   always_comb begin
      bits_in  = bits_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      phase_in = phase_ff;
      tick_in  = tick_ff;
      cyc_in   = cyc_ff;
      last_in  = last_ff;
      accepted = 1'b0;
      if (item.func) begin
         if (phase_ff == PH_IDLE) begin
            accepted = 1'b1;
            bits_in  = entry[4:0];
            len_in   = entry[7:5];
            idx_in   = 3'd0;
            last_in  = item.end_of_message;
            if (entry[7:5] != 3'd0) begin
               phase_in = PH_HIGH;
               tick_in  = {4'd0, half1};
               cyc_in   = entry[0] ? {cyc1, 1'b0} : {1'b0, cyc1};
            end else begin
               phase_in = PH_CGAP;
               tick_in  = {3'd0, gap1, 1'b0};
            end
         end
      end else if (phase_ff != PH_IDLE) begin
         tick_in = tick_dec;
         if (tick_dec == '0) begin
            case (phase_ff)
               PH_HIGH: begin
                  phase_in = PH_LOW;
                  tick_in  = {4'd0, half1};
               end
               PH_LOW: begin
                  cyc_in = cyc_dec;
                  if (cyc_dec != '0) begin
                     phase_in = PH_HIGH;
                     tick_in  = {4'd0, half1};
                  end else begin
                     phase_in = PH_EGAP;
                     tick_in  = {4'd0, gap1};
                  end
               end
               PH_EGAP: begin
                  idx_in = idx_inc;
                  if (idx_inc < len_ff) begin
                     phase_in = PH_HIGH;
                     tick_in  = {4'd0, half1};
                     cyc_in   = is_dash(bits_ff, idx_inc) ? {cyc1, 1'b0} : {1'b0, cyc1};
                  end else begin
                     phase_in = PH_CGAP;
                     tick_in  = {3'd0, gap1, 1'b0};
                  end
               end
               PH_CGAP: begin
                  if (last_ff) begin
                     phase_in = PH_FINISH;
                     tick_in  = {1'b0, gap1, 3'd0};
                  end else begin
                     phase_in = PH_IDLE;
                     tick_in  = '0;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
                  tick_in  = '0;
               end
            endcase
         end
      end
   end

   assign sounding = (phase_in == PH_HIGH) || (phase_in == PH_LOW);
   assign dash     = is_dash(bits_in, idx_in);

   always_comb begin
      result.speaker_level = (phase_in == PH_HIGH);
      result.red_lamp      = sounding && !dash;
      result.yellow_lamp   = sounding && dash;
      result.green_lamp    = (phase_in == PH_FINISH);
      result.busy_res      = (phase_in != PH_IDLE);
      result.accepted      = accepted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff  <= '0;
         len_ff   <= '0;
         idx_ff   <= '0;
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         cyc_ff   <= '0;
         last_ff  <= 1'b0;
      end else if (step) begin
         bits_ff  <= bits_in;
         len_ff   <= len_in;
         idx_ff   <= idx_in;
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         cyc_ff   <= cyc_in;
         last_ff  <= last_in;
      end
   end

endmodule
`default_nettype wire

[hdl/morse_character_player.sv]
// Morse character player.
// Request channel (req_): tuser = func (0 tick, 1 offer a character),
// tdata = char_code, tlast = end_of_message. Each transaction is one step:
// a tick advances the playing character by one tick of time, an offer
// starts a character if nothing is playing and is refused otherwise.
// Response channel (rsp_): one transaction per request, carrying the
// speaker level, red/yellow/green lamps, busy and accepted after the step.
// Configuration (csr_): write-only registers, index 0 tone half period in
// ticks, 1 tone cycles per dot, 2 unit gap ticks; zero acts as one. Write
// only while idle.
// From request to response the path is the input register, then the step logic
// into the response register. Throughput: one transaction per cycle while
// rsp_tready is high, set by the state update that steps once per transaction.
// Reset (synchronous) returns to idle with default registers 500, 75 and
// 15000. When the receiver stalls the response register holds, the input
// register takes one more transaction, then req_tready drops.
// Depends on mcp_pkg, mcp_in_stage, mcp_player.
`default_nettype none
module morse_character_player (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,  // char_code
   input  wire logic                            req_tlast,
   input  wire logic                            req_tuser,  // func
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // speaker_level, red_lamp, yellow_lamp, green_lamp, busy_res, accepted, 2 pad
   output logic [7:0]                           rsp_tdata,
   input  wire logic                            csr_wr_en,
   input  wire logic [mcp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mcp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mcp_pkg::*;

   cfg_type    cfg_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       item_valid, take;
   item_type   item;
   result_type result;

   assign take         = item_valid && (!out_valid_ff || rsp_tready);
   assign out_valid_in = take || (out_valid_ff && !rsp_tready);

   mcp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   mcp_player u_player (
      .clock  (clock),
      .reset  (reset),
      .step   (take),
      .item   (item),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period <= HALF_PERIOD_RST;
         cfg_ff.cycles      <= CYCLES_RST;
         cfg_ff.unit_gap    <= UNIT_GAP_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HALF_PERIOD: cfg_ff.half_period <= csr_wdata;
            CSR_CYCLES:      cfg_ff.cycles      <= csr_wdata[7:0];
            CSR_UNIT_GAP:    cfg_ff.unit_gap    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff};

endmodule
`default_nettype wire

[sim/morse_character_player_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for morse_character_player: streams characters and ticks,
// predicts the speaker and lamp state after every step and checks each response.
// Depends on mcp_pkg and the morse_character_player RTL.
module morse_character_player_tb;
   import mcp_pkg::*;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'd0;   // char_code
   logic                  req_tlast  = 1'b0;   // end_of_message
   logic                  req_tuser  = 1'b0;   // func
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;           // speaker, red, yellow, green, busy, accepted, pad
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   morse_character_player uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   item_type   pending_steps[$];
   result_type expected_lamps[$];
   item_type   step_on_bus;

   int send_idle_pct = 32;
   int recv_idle_pct = 77;
   int stall_asks    = 0;
   int stalls_done   = 0;
   int hold_left     = 0;

   int errors         = 0;
   int steps_queued   = 0;
   int steps_sent     = 0;
   int responses_seen = 0;
   int offers_taken   = 0;
   int offers_refused = 0;

   // player state as predicted
   cfg_type              cfg_live = '{HALF_PERIOD_RST, CYCLES_RST, UNIT_GAP_RST};
   logic [PHASE_W-1:0]   cur_phase   = PH_IDLE;
   logic [TICK_W-1:0]    ticks_left  = '0;
   logic [CYCLE_W-1:0]   cycles_left = '0;
   logic [4:0]           pat_bits    = '0;
   logic [2:0]           pat_len     = '0;
   logic [2:0]           elem_idx    = '0;
   logic                 finish_due  = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #200_000;
      $display("tb: failure");
      $finish;
   end

   function automatic string morse_text(input logic [7:0] ch);
      logic [7:0] c;
      c = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
      case (c)
         "a": return ".-";    "b": return "-...";  "c": return "-.-.";  "d": return "-..";
         "e": return ".";     "f": return "..-.";  "g": return "--.";   "h": return "....";
         "i": return "..";    "j": return ".---";  "k": return "-.-";   "l": return ".-..";
         "m": return "--";    "n": return "-.";    "o": return "---";   "p": return ".--.";
         "q": return "--.-";  "r": return ".-.";   "s": return "...";   "t": return "-";
         "u": return "..-";   "v": return "...-";  "w": return ".--";   "x": return "-..-";
         "y": return "-.--";  "z": return "--..";
         "0": return "-----"; "1": return ".----"; "2": return "..---"; "3": return "...--";
         "4": return "....-"; "5": return "....."; "6": return "-...."; "7": return "--...";
         "8": return "---.."; "9": return "----.";
         default: return "";
      endcase
   endfunction

   // {length, dash mask with element 0 in bit 0}
   function automatic logic [7:0] pattern_of(input logic [7:0] ch);
      string      code;
      logic [7:0] entry;
      code = morse_text(ch);
      entry = 8'd0;
      entry[7:5] = 3'(code.len());
      for (int i = 0; i < code.len(); i++)
         if (code[i] == "-") entry[i] = 1'b1;
      return entry;
   endfunction

   function automatic logic [15:0] at_least_1(input logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

   function automatic void start_tone();
      logic [7:0] ext;
      ext = {3'd0, pat_bits};
      cycles_left = (ext[elem_idx] ? 9'd2 : 9'd1) * 9'(at_least_1({8'd0, cfg_live.cycles}));
      cur_phase   = PH_HIGH;
      ticks_left  = 20'(at_least_1(cfg_live.half_period));
   endfunction

   function automatic void enter_char_gap();
      cur_phase  = PH_CGAP;
      ticks_left = 20'(at_least_1(cfg_live.unit_gap)) * 20'd2;
   endfunction

   function automatic result_type advance_player(input item_type it);
      result_type r;
      logic [7:0] entry;
      logic [7:0] ext;
      logic       sounding;
      r = '0;
      if (it.func) begin
         if (cur_phase == PH_IDLE) begin
            entry      = pattern_of(it.char_code);
            pat_bits   = entry[4:0];
            pat_len    = entry[7:5];
            elem_idx   = 3'd0;
            finish_due = it.end_of_message;
            r.accepted = 1'b1;
            offers_taken++;
            if (pat_len != 3'd0) start_tone();
            else enter_char_gap();
         end else begin
            offers_refused++;
         end
      end else if (cur_phase != PH_IDLE) begin
         ticks_left = ticks_left - 20'd1;
         if (ticks_left == 20'd0) begin
            case (cur_phase)
               PH_HIGH: begin
                  cur_phase  = PH_LOW;
                  ticks_left = 20'(at_least_1(cfg_live.half_period));
               end
               PH_LOW: begin
                  cycles_left = cycles_left - 9'd1;
                  if (cycles_left != 9'd0) begin
                     cur_phase  = PH_HIGH;
                     ticks_left = 20'(at_least_1(cfg_live.half_period));
                  end else begin
                     cur_phase  = PH_EGAP;
                     ticks_left = 20'(at_least_1(cfg_live.unit_gap));
                  end
               end
               PH_EGAP: begin
                  elem_idx = elem_idx + 3'd1;
                  if (elem_idx < pat_len) start_tone();
                  else enter_char_gap();
               end
               PH_CGAP: begin
                  if (finish_due) begin
                     cur_phase  = PH_FINISH;
                     ticks_left = 20'(at_least_1(cfg_live.unit_gap)) * 20'd8;
                  end else begin
                     cur_phase  = PH_IDLE;
                     ticks_left = 20'd0;
                  end
               end
               default: begin
                  cur_phase  = PH_IDLE;
                  ticks_left = 20'd0;
               end
            endcase
         end
      end
      ext = {3'd0, pat_bits};
      sounding = (cur_phase == PH_HIGH) || (cur_phase == PH_LOW);
      r.speaker_level = (cur_phase == PH_HIGH);
      r.red_lamp      = sounding && !ext[elem_idx];
      r.yellow_lamp   = sounding && ext[elem_idx];
      r.green_lamp    = (cur_phase == PH_FINISH);
      r.busy_res      = (cur_phase != PH_IDLE);
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_lamps.push_back(advance_player(step_on_bus));
            steps_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_steps.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_steps.pop_front();
               step_on_bus <= nxt;
               req_tvalid  <= 1'b1;
               req_tuser   <= nxt.func;
               req_tdata   <= nxt.char_code;
               req_tlast   <= nxt.end_of_message;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response ready, with a long hold-off whenever the test asks for one
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_asks != stalls_done) begin
         stalls_done <= stalls_done + 1;
         hold_left   <= 300;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // response monitor
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen++;
         if (expected_lamps.size() == 0) begin
            $error("response transaction with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            want = expected_lamps.pop_front();
            got  = rsp_tdata[5:0];
            check_field("speaker_level", want.speaker_level, got.speaker_level);
            check_field("red_lamp", want.red_lamp, got.red_lamp);
            check_field("yellow_lamp", want.yellow_lamp, got.yellow_lamp);
            check_field("green_lamp", want.green_lamp, got.green_lamp);
            check_field("busy_res", want.busy_res, got.busy_res);
            check_field("accepted", want.accepted, got.accepted);
            check_field("pad", 0, rsp_tdata[7:6]);
         end
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_HALF_PERIOD: cfg_live.half_period = val;
         CSR_CYCLES:      cfg_live.cycles      = val[7:0];
         CSR_UNIT_GAP:    cfg_live.unit_gap    = val;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_offer(input logic [7:0] ch, input logic eom);
      item_type it;
      it.func = 1'b1;
      it.char_code = ch;
      it.end_of_message = eom;
      pending_steps.push_back(it);
      steps_queued++;
   endtask

   // ticks carry random char and flag bits; noise_pct adds offers while playing
   task automatic feed_ticks(input int n, input int noise_pct);
      item_type it;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < noise_pct)
            queue_offer(8'($urandom_range(255)), 1'($urandom_range(1)));
         it.func = 1'b0;
         it.char_code = 8'($urandom_range(255));
         it.end_of_message = 1'($urandom_range(1));
         pending_steps.push_back(it);
         steps_queued++;
      end
   endtask

   function automatic int char_ticks(input logic [7:0] ch, input logic eom);
      logic [7:0] entry;
      int hp;
      int cyc;
      int gap;
      int total;
      entry = pattern_of(ch);
      hp    = at_least_1(cfg_live.half_period);
      cyc   = at_least_1({8'd0, cfg_live.cycles});
      gap   = at_least_1(cfg_live.unit_gap);
      total = 2 * gap + (eom ? 8 * gap : 0);
      for (int i = 0; i < entry[7:5]; i++)
         total += (entry[i] ? 2 : 1) * cyc * 2 * hp + gap;
      return total;
   endfunction

   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(99);
      if (r < 35) return "A" + 8'($urandom_range(25));
      if (r < 60) return "a" + 8'($urandom_range(25));
      if (r < 85) return "0" + 8'($urandom_range(9));
      return 8'($urandom_range(255));
   endfunction

   // mostly full characters; some cut short so the next offer is refused
   task automatic play_char(input logic [7:0] ch, input logic eom);
      int d;
      int r;
      d = char_ticks(ch, eom);
      r = $urandom_range(99);
      queue_offer(ch, eom);
      if (r < 20) d = $urandom_range(d - 1, 0);
      else if (r < 30) d += $urandom_range(4, 1);
      feed_ticks(d, 6);
   endtask

   task automatic wait_drained();
      while (pending_steps.size() != 0 || req_tvalid || expected_lamps.size() != 0)
         @(negedge clock);
   endtask

   task automatic finish_playing();
      wait_drained();
      while (cur_phase != PH_IDLE) begin
         feed_ticks(8, 0);
         wait_drained();
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic random_run(input int n);
      int stop_at;
      stop_at = steps_queued + n;
      while (steps_queued < stop_at)
         play_char(pick_char(), ($urandom_range(99) < 30));
      finish_playing();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: zero registers act as one
      write_csr(CSR_HALF_PERIOD, 16'd0);
      write_csr(CSR_CYCLES, 16'd0);
      write_csr(CSR_UNIT_GAP, 16'd0);
      feed_ticks(1, 0);
      queue_offer("E", 1'b0);
      queue_offer("T", 1'b1);    // refused, busy
      feed_ticks(5, 0);
      queue_offer(8'hFF, 1'b1);  // empty pattern with finish lamp
      feed_ticks(10, 0);
      queue_offer(8'h00, 1'b0);
      feed_ticks(2, 0);
      finish_playing();

      write_csr(CSR_HALF_PERIOD, 16'd1);
      write_csr(CSR_CYCLES, 16'd1);
      write_csr(CSR_UNIT_GAP, 16'd1);
      random_run(160);

      send_idle_pct = 77;
      recv_idle_pct = 32;
      write_csr(CSR_HALF_PERIOD, 16'd2);
      write_csr(CSR_UNIT_GAP, 16'd2);
      random_run(160);

      // largest settings, receiver held off while requests keep coming
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_HALF_PERIOD, 16'hFFFF);
      write_csr(CSR_CYCLES, 16'h00FF);
      write_csr(CSR_UNIT_GAP, 16'hFFFF);
      stall_asks++;
      queue_offer("0", 1'b1);
      feed_ticks(200, 6);
      wait_drained();
      repeat (20) @(posedge clock);

      $display("summary: %0d steps sent, %0d responses checked, %0d characters started",
               steps_sent, responses_seen, offers_taken);
      $display("summary: %0d offers refused while busy, settings from zero to full scale",
               offers_refused);
      if (errors == 0 && expected_lamps.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
